// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the frame encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// A property that holds at every clock edge outside reset.
`define IRAC_ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// A consequent that holds in the same cycle as its antecedent.
`define IRAC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// A consequent that holds in the cycle after its antecedent.
`define IRAC_ASSERT_FOLLOWS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define IRAC_ASSERT_HOLDS(label, clk, rst, prop)
`define IRAC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define IRAC_ASSERT_FOLLOWS(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/irac_pkg.sv =====
// Types, constants and code tables of the IR air-conditioner frame encoder.
`timescale 1ns / 1ps
package irac_pkg;

   localparam int unsigned NUM_REGS = 7;
   localparam int unsigned REG_W    = 16;
   localparam int unsigned WORD_W   = 24;
   localparam int unsigned POS_W    = 8;

   typedef enum logic [2:0] {
      KIND_START_STATE  = 3'd0,
      KIND_START_TOGGLE = 3'd1,
      KIND_START_EXTRA  = 3'd2,
      KIND_START_RAW    = 3'd3,
      KIND_NEXT         = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_REJECTED = 2'd1,
      STATUS_IDLE     = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      REG_LEAD_MARK  = 3'd0,
      REG_LEAD_SPACE = 3'd1,
      REG_BIT_MARK   = 3'd2,
      REG_ONE_SPACE  = 3'd3,
      REG_ZERO_SPACE = 3'd4,
      REG_STOP_MARK  = 3'd5,
      REG_GAP        = 3'd6
   } reg_index_type;

   typedef enum logic [2:0] {
      MODE_OFF  = 3'd0,
      MODE_COOL = 3'd1,
      MODE_AUTO = 3'd2,
      MODE_DRY  = 3'd3,
      MODE_HEAT = 3'd4,
      MODE_FAN  = 3'd5
   } mode_type;

   typedef logic [REG_W-1:0] duration_type;
   typedef duration_type [NUM_REGS-1:0] regs_type;

   localparam regs_type REG_RESET = {
      16'd5244, 16'd552, 16'd552, 16'd1656, 16'd552, 16'd4416, 16'd4692
   };

   localparam logic [WORD_W-1:0] WORD_BASE     = 24'hB20F00;
   localparam logic [WORD_W-1:0] WORD_OFF      = 24'hB27BE0;
   localparam logic [WORD_W-1:0] FAN_FORCED    = 24'h001000;
   localparam logic [WORD_W-1:0] FAN_ONLY_TEMP = 24'h0000E0;
   localparam logic [7:0]        TEMP_LOW      = 8'd17;
   localparam logic [7:0]        TEMP_HIGH     = 8'd30;
   localparam logic [POS_W-1:0]  GAP_POS       = 8'd99;
   localparam logic [POS_W-1:0]  FRAME2_START  = 8'd100;
   localparam logic [POS_W-1:0]  STOP_OFFSET   = 8'd98;
   localparam logic [POS_W-1:0]  SEQ_LAST      = 8'd198;

   typedef struct packed {
      logic [2:0]        kind;
      logic [2:0]        mode;
      logic [2:0]        fan;
      logic [7:0]        temp;
      logic [3:0]        select;
      logic [WORD_W-1:0] raw_code;
   } req_payload_type;

   typedef struct packed {
      duration_type      duration;
      logic              is_mark;
      logic              last;
      logic [1:0]        status;
      logic [WORD_W-1:0] word;
      logic [POS_W-1:0]  position;
   } rsp_payload_type;

   // Gray-like temperature code, indexed by the clamped setpoint minus 17.
   function automatic logic [7:0] temp_nibble(input logic [3:0] idx);
      logic [7:0] code;
      unique case (idx)
         4'd0:    code = 8'h00;
         4'd1:    code = 8'h10;
         4'd2:    code = 8'h30;
         4'd3:    code = 8'h20;
         4'd4:    code = 8'h60;
         4'd5:    code = 8'h70;
         4'd6:    code = 8'h50;
         4'd7:    code = 8'h40;
         4'd8:    code = 8'hC0;
         4'd9:    code = 8'hD0;
         4'd10:   code = 8'h90;
         4'd11:   code = 8'h80;
         4'd12:   code = 8'hA0;
         4'd13:   code = 8'hB0;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

   function automatic logic [WORD_W-1:0] fan_bits(input logic [1:0] fan);
      logic [WORD_W-1:0] code;
      unique case (fan)
         2'd0:    code = 24'h00B000;
         2'd1:    code = 24'h009000;
         2'd2:    code = 24'h005000;
         default: code = 24'h003000;
      endcase
      return code;
   endfunction

   function automatic logic [WORD_W-1:0] mode_code(input logic [2:0] mode);
      logic [WORD_W-1:0] code;
      unique case (mode)
         MODE_AUTO: code = 24'h000008;
         MODE_DRY:  code = 24'h000004;
         MODE_HEAT: code = 24'h00000C;
         MODE_FAN:  code = 24'h000004;
         default:   code = 24'h000000;
      endcase
      return code;
   endfunction

   function automatic logic [WORD_W-1:0] toggle_word(input logic [2:0] idx);
      logic [WORD_W-1:0] code;
      unique case (idx)
         3'd0:    code = 24'hB27BE0;
         3'd1:    code = 24'hB26BE0;
         3'd2:    code = 24'hB20FE0;
         3'd3:    code = 24'hB5F5A2;
         3'd4:    code = 24'hB5F5A5;
         default: code = 24'hB2E003;
      endcase
      return code;
   endfunction

   function automatic logic [WORD_W-1:0] extra_word(input logic [1:0] idx);
      logic [WORD_W-1:0] code;
      unique case (idx)
         2'd0:    code = 24'hB5F5B6;
         2'd1:    code = 24'hB2F5A2;
         2'd2:    code = 24'hB2BFE4;
         default: code = 24'hB5F5AA;
      endcase
      return code;
   endfunction

endpackage

// ===== rtl/core/irac_stream_if.sv =====
// Valid/ready stream interface carrying one item per handshake.
`timescale 1ns / 1ps
interface irac_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/irac_csr.sv =====
// Timing register file of the frame encoder.
`timescale 1ns / 1ps
module irac_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_write_data,
   output irac_pkg::regs_type regs
);
   irac_pkg::regs_type regs_ff;

   // Writes beyond the last register are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= irac_pkg::REG_RESET;
      end else if (csr_write_enable && (csr_index <= irac_pkg::REG_GAP)) begin
         regs_ff[csr_index] <= csr_write_data;
      end
   end

   assign regs = regs_ff;
endmodule

// ===== rtl/core/irac_word_build.sv =====
// Selection of the command word for a start item.
`timescale 1ns / 1ps
module irac_word_build (
   input  irac_pkg::req_payload_type req,
   output logic [23:0]               word,
   output logic                      ok
);
   logic [7:0]  temp_clamped;
   logic [7:0]  temp_offset;
   logic [23:0] temp_code;
   logic [23:0] fan_code;
   logic [23:0] state_word;
   logic        mode_valid;

   always_comb begin
      priority if (req.temp < irac_pkg::TEMP_LOW) begin
         temp_clamped = irac_pkg::TEMP_LOW;
      end else if (req.temp > irac_pkg::TEMP_HIGH) begin
         temp_clamped = irac_pkg::TEMP_HIGH;
      end else begin
         temp_clamped = req.temp;
      end
   end

   assign temp_offset = temp_clamped - irac_pkg::TEMP_LOW;

   // Fan-only mode carries a marker in place of the temperature code.
   assign temp_code = (req.mode == irac_pkg::MODE_FAN) ? irac_pkg::FAN_ONLY_TEMP
                    : {16'd0, irac_pkg::temp_nibble(temp_offset[3:0])};

   // Auto and dry run the fan at a fixed setting; unknown fan codes act as auto.
   assign fan_code = ((req.mode == irac_pkg::MODE_AUTO) || (req.mode == irac_pkg::MODE_DRY))
                   ? irac_pkg::FAN_FORCED
                   : irac_pkg::fan_bits(req.fan[2] ? 2'd0 : req.fan[1:0]);

   assign state_word = irac_pkg::WORD_BASE | irac_pkg::mode_code(req.mode)
                     | temp_code | fan_code;

   assign mode_valid = (req.mode >= irac_pkg::MODE_COOL) && (req.mode <= irac_pkg::MODE_FAN);

   always_comb begin
      word = '0;
      ok   = 1'b0;
      unique case (req.kind)
         irac_pkg::KIND_START_STATE: begin
            word = state_word;
            ok   = mode_valid;
         end
         irac_pkg::KIND_START_TOGGLE: begin
            word = irac_pkg::toggle_word(req.select[2:0]);
            ok   = (req.select < 4'd6);
         end
         irac_pkg::KIND_START_EXTRA: begin
            word = irac_pkg::extra_word(req.select[1:0]);
            ok   = (req.select < 4'd4);
         end
         irac_pkg::KIND_START_RAW: begin
            word = req.raw_code;
            ok   = 1'b1;
         end
         default: begin
            word = '0;
            ok   = 1'b0;
         end
      endcase
   end
endmodule

// ===== rtl/core/irac_timing.sv =====
// Duration lookup for one position of the two-frame sequence.
`timescale 1ns / 1ps
module irac_timing (
   input  irac_pkg::regs_type     regs,
   input  logic [23:0]            word,
   input  logic [7:0]             position,
   output irac_pkg::duration_type duration
);
   logic [7:0] frame_pos;
   logic [7:0] data_pos;
   logic [5:0] bit_num;
   logic [7:0] byte_val;
   logic       bit_val;

   // Both frames share the same layout; the second starts after the gap.
   assign frame_pos = (position < irac_pkg::GAP_POS) ? position
                    : position - irac_pkg::FRAME2_START;
   assign data_pos  = frame_pos - 8'd2;
   assign bit_num   = data_pos[6:1];

   always_comb begin
      unique case (bit_num[5:4])
         2'd0:    byte_val = word[23:16];
         2'd1:    byte_val = word[15:8];
         default: byte_val = word[7:0];
      endcase
   end

   // The second half of each 16-bit group sends the inverted byte.
   assign bit_val = byte_val[3'd7 - bit_num[2:0]] ^ bit_num[3];

   always_comb begin
      priority if (position == irac_pkg::GAP_POS) begin
         duration = regs[irac_pkg::REG_GAP];
      end else if (frame_pos == 8'd0) begin
         duration = regs[irac_pkg::REG_LEAD_MARK];
      end else if (frame_pos == 8'd1) begin
         duration = regs[irac_pkg::REG_LEAD_SPACE];
      end else if (frame_pos == irac_pkg::STOP_OFFSET) begin
         duration = regs[irac_pkg::REG_STOP_MARK];
      end else if (!data_pos[0]) begin
         duration = regs[irac_pkg::REG_BIT_MARK];
      end else if (bit_val) begin
         duration = regs[irac_pkg::REG_ONE_SPACE];
      end else begin
         duration = regs[irac_pkg::REG_ZERO_SPACE];
      end
   end
endmodule

// ===== rtl/core/ir_ac_frame_encoder_core.sv =====
// Top level of the IR air-conditioner frame encoder.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// The encoder turns air-conditioner commands into the timing sequence of a
// two-frame infrared burst. A start item (state, toggle, extra or raw)
// selects the 24-bit command word and answers with that word; each
// following next item returns one duration of the 199-entry sequence
// (leader, three bytes each followed by its inverse, stop mark, gap, and the
// same frame again), with even positions being marks. A start item with an
// invalid selection is answered with the rejected status and the off code,
// and cancels any sequence in progress; a next item with no sequence active
// is answered with the idle status. Every item gives exactly one result.
// The block takes one item per clock cycle for as long as results are taken;
// each item is held in the input register and then passes to the result
// register through the single combinational pass between the two. The seven
// timing registers are written through the csr_ port; the user is to write
// them only while the block is idle, which the block itself does not enforce.
// Writes to an index beyond the last register are ignored.
module ir_ac_frame_encoder_core (
   input  logic                 clock,
   input  logic                 reset,
   irac_stream_if.sink          req_if,
   irac_stream_if.source        rsp_if,
   input  logic                 csr_write_enable,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_write_data
);
   irac_pkg::regs_type        regs;
   irac_pkg::req_payload_type in_data_ff;
   logic                      in_valid_ff;
   irac_pkg::rsp_payload_type out_data_ff;
   logic                      out_valid_ff;
   irac_pkg::rsp_payload_type rsp_in;
   logic [23:0]               held_word_ff;
   logic [23:0]               held_word_in;
   logic [7:0]                index_ff;
   logic [7:0]                index_in;
   logic                      active_ff;
   logic                      active_in;
   logic [23:0]               start_word;
   logic                      start_ok;
   irac_pkg::duration_type    duration;
   logic                      advance;
   logic                      fire;
   logic                      req_accept;

   irac_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .regs             (regs)
   );

   irac_word_build u_word_build (
      .req  (in_data_ff),
      .word (start_word),
      .ok   (start_ok)
   );

   irac_timing u_timing (
      .regs     (regs),
      .word     (held_word_ff),
      .position (index_ff),
      .duration (duration)
   );

   // The result register frees up whenever its item is taken, so the input
   // register can move on in the same cycle.
   assign advance      = !out_valid_ff || rsp_if.ready;
   assign fire         = in_valid_ff && advance;
   assign req_if.ready = !in_valid_ff || advance;
   assign req_accept   = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_if.payload;
      end
   end

   // One item is processed against the sequence state in a single pass.
   always_comb begin
      rsp_in       = '0;
      held_word_in = held_word_ff;
      index_in     = index_ff;
      active_in    = active_ff;
      if (in_data_ff.kind == irac_pkg::KIND_NEXT) begin
         if (!active_ff) begin
            rsp_in.status = irac_pkg::STATUS_IDLE;
            active_in     = 1'b0;
         end else begin
            rsp_in.duration = duration;
            rsp_in.is_mark  = !index_ff[0];
            rsp_in.last     = (index_ff == irac_pkg::SEQ_LAST);
            rsp_in.status   = irac_pkg::STATUS_OK;
            rsp_in.word     = held_word_ff;
            rsp_in.position = index_ff;
            if (index_ff == irac_pkg::SEQ_LAST) begin
               active_in = 1'b0;
               index_in  = '0;
            end else begin
               index_in = index_ff + 8'd1;
            end
         end
      end else if (start_ok) begin
         held_word_in  = start_word;
         index_in      = '0;
         active_in     = 1'b1;
         rsp_in.status = irac_pkg::STATUS_OK;
         rsp_in.word   = start_word;
      end else begin
         // A rejected selection cancels the sequence but keeps the held word.
         index_in      = '0;
         active_in     = 1'b0;
         rsp_in.status = irac_pkg::STATUS_REJECTED;
         rsp_in.word   = irac_pkg::WORD_OFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_word_ff <= '0;
         index_ff     <= '0;
         active_ff    <= 1'b0;
      end else if (fire) begin
         held_word_ff <= held_word_in;
         index_ff     <= index_in;
         active_ff    <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff <= rsp_in;
      end
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_data_ff;

   `IRAC_ASSERT_HOLDS(a_index_in_range, clock, reset, index_ff <= irac_pkg::SEQ_LAST)
   `IRAC_ASSERT_IMPLIES(a_index_needs_active, clock, reset, index_ff != '0, active_ff)
   `IRAC_ASSERT_FOLLOWS(a_last_ends_sequence, clock, reset, fire && rsp_in.last, !active_ff && (index_ff == '0))
   `IRAC_ASSERT_IMPLIES(a_idle_result_empty, clock, reset, out_valid_ff && (out_data_ff.status == irac_pkg::STATUS_IDLE), (out_data_ff.word == '0) && (out_data_ff.duration == '0))
endmodule

// ===== bench/ir_ac_frame_encoder_core_tb.sv =====
// Self-checking testbench for the IR air-conditioner frame encoder core.
`timescale 1ns / 1ps
module ir_ac_frame_encoder_core_tb;

   // Clocking and reset.
   localparam int HALF_PERIOD  = 1;
   localparam int RESET_CYCLES = 12;

   // Each side holds back in roughly this many cycles of a hundred.
   localparam int unsigned IDLE_PCT = 27;

   // Cycles allowed to settle after the last answer, before the timing
   // registers are touched or the run ends.
   localparam int SETTLE_CYCLES = 4;

   // Cycles without any item moving on either side before the run is abandoned.
   localparam int unsigned STALL_LIMIT = 1000;

   // Items per randomised phase.
   localparam int unsigned PHASE_ITEMS = 240;

   // Codes that the package leaves unnamed.
   localparam logic [2:0] KIND_RESERVED_LO = 3'd5;
   localparam logic [2:0] KIND_RESERVED_HI = 3'd7;
   localparam logic [2:0] MODE_RESERVED_LO = 3'd6;
   localparam logic [2:0] MODE_RESERVED_HI = 3'd7;
   localparam logic [2:0] REG_SPARE        = 3'd7;
   localparam logic [3:0] SELECT_MAX       = 4'hF;
   localparam int         NUM_TOGGLES      = 6;
   localparam int         NUM_EXTRAS       = 4;

   // Mode nibbles of the state word; fan-only shares the dry nibble.
   localparam logic [irac_pkg::WORD_W-1:0] MODE_CODE_AUTO    = 24'h000008;
   localparam logic [irac_pkg::WORD_W-1:0] MODE_CODE_DRY_FAN = 24'h000004;
   localparam logic [irac_pkg::WORD_W-1:0] MODE_CODE_HEAT    = 24'h00000C;

   // Temperature codes from 17 to 30 degrees, fan speed codes, and the fixed
   // command words of the toggle and extra tables.
   localparam logic [7:0] TEMP_CODE [14] = '{
      8'h00, 8'h10, 8'h30, 8'h20, 8'h60, 8'h70, 8'h50,
      8'h40, 8'hC0, 8'hD0, 8'h90, 8'h80, 8'hA0, 8'hB0
   };
   localparam logic [irac_pkg::WORD_W-1:0] FAN_CODE [4] = '{
      24'h00B000, 24'h009000, 24'h005000, 24'h003000
   };
   localparam logic [irac_pkg::WORD_W-1:0] TOGGLE_WORDS [NUM_TOGGLES] = '{
      24'hB27BE0, 24'hB26BE0, 24'hB20FE0, 24'hB5F5A2, 24'hB5F5A5, 24'hB2E003
   };
   localparam logic [irac_pkg::WORD_W-1:0] EXTRA_WORDS [NUM_EXTRAS] = '{
      24'hB5F5B6, 24'hB2F5A2, 24'hB2BFE4, 24'hB5F5AA
   };

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [15:0] csr_write_data;

   irac_stream_if #(.payload_type(irac_pkg::req_payload_type)) req_ch ();
   irac_stream_if #(.payload_type(irac_pkg::rsp_payload_type)) rsp_ch ();

   ir_ac_frame_encoder_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Commands waiting to be offered, and the answers that the encoder owes.
   irac_pkg::req_payload_type command_queue[$];
   irac_pkg::rsp_payload_type owed_answers[$];

   // Our own copy of the encoder: timing registers, held word, position
   // within the burst and whether a burst is in progress.
   irac_pkg::regs_type               timing_regs;
   logic [irac_pkg::WORD_W-1:0]      burst_word   = '0;
   logic [irac_pkg::POS_W-1:0]       burst_pos    = '0;
   logic                             burst_active = 1'b0;

   int unsigned mismatches = 0;
   int unsigned quiet_cycles;
   logic        no_stall_phase;

   always #HALF_PERIOD clock = ~clock;

   // Builds the command word of a state item: base code, mode nibble,
   // temperature code (or the fan-only marker) and fan speed (forced for
   // auto and dry; speeds above high count as auto).
   function automatic logic [irac_pkg::WORD_W-1:0] state_word(logic [2:0] mode,
                                                              logic [2:0] fan,
                                                              logic [7:0] temp);
      logic [irac_pkg::WORD_W-1:0] w;
      logic [7:0]                  t;
      logic [3:0]                  idx;
      w = irac_pkg::WORD_BASE;
      case (mode)
         irac_pkg::MODE_AUTO:                    w |= MODE_CODE_AUTO;
         irac_pkg::MODE_DRY, irac_pkg::MODE_FAN: w |= MODE_CODE_DRY_FAN;
         irac_pkg::MODE_HEAT:                    w |= MODE_CODE_HEAT;
         default:                                ;
      endcase
      if (mode == irac_pkg::MODE_FAN) begin
         w |= irac_pkg::FAN_ONLY_TEMP;
      end else begin
         if (temp < irac_pkg::TEMP_LOW) begin
            t = irac_pkg::TEMP_LOW;
         end else if (temp > irac_pkg::TEMP_HIGH) begin
            t = irac_pkg::TEMP_HIGH;
         end else begin
            t = temp;
         end
         idx = 4'(t - irac_pkg::TEMP_LOW);
         w |= {16'h0000, TEMP_CODE[idx]};
      end
      if (mode == irac_pkg::MODE_AUTO || mode == irac_pkg::MODE_DRY) begin
         w |= irac_pkg::FAN_FORCED;
      end else begin
         w |= FAN_CODE[fan[2] ? 2'd0 : fan[1:0]];
      end
      return w;
   endfunction

   // Duration at one position of the burst. Position 99 is the gap between
   // the two frames; within a frame the leader comes first, then 48 bits as
   // mark/space pairs (each byte followed by its inverse), then the stop mark.
   function automatic irac_pkg::duration_type duration_at(logic [irac_pkg::WORD_W-1:0] w,
                                                          logic [irac_pkg::POS_W-1:0] p);
      logic [irac_pkg::POS_W-1:0] f;
      logic [irac_pkg::POS_W-1:0] d;
      logic [5:0]                 n;
      logic [7:0]                 byte_val;
      logic                       bit_val;
      irac_pkg::duration_type     t;
      if (p == irac_pkg::GAP_POS) begin
         t = timing_regs[irac_pkg::REG_GAP];
      end else begin
         f = (p < irac_pkg::GAP_POS) ? p : p - irac_pkg::FRAME2_START;
         if (f == 8'd0) begin
            t = timing_regs[irac_pkg::REG_LEAD_MARK];
         end else if (f == 8'd1) begin
            t = timing_regs[irac_pkg::REG_LEAD_SPACE];
         end else if (f == irac_pkg::STOP_OFFSET) begin
            t = timing_regs[irac_pkg::REG_STOP_MARK];
         end else begin
            d = f - 8'd2;
            if (!d[0]) begin
               t = timing_regs[irac_pkg::REG_BIT_MARK];
            end else begin
               n        = d[6:1];
               byte_val = w[irac_pkg::WORD_W - 1 - 8 * n[5:4] -: 8];
               bit_val  = byte_val[7 - n[2:0]] ^ n[3];
               t = bit_val ? timing_regs[irac_pkg::REG_ONE_SPACE]
                           : timing_regs[irac_pkg::REG_ZERO_SPACE];
            end
         end
      end
      return t;
   endfunction

   // Works out the answer to one accepted item and moves our copy of the
   // encoder on. Every item gets exactly one answer.
   function automatic irac_pkg::rsp_payload_type encode_item(irac_pkg::req_payload_type item);
      irac_pkg::rsp_payload_type   ans;
      logic [irac_pkg::WORD_W-1:0] cmd;
      logic                        chosen;
      ans    = '0;
      cmd    = '0;
      chosen = 1'b0;
      case (item.kind)
         irac_pkg::KIND_NEXT: begin
            if (!burst_active) begin
               ans.status = irac_pkg::STATUS_IDLE;
            end else begin
               ans.duration = duration_at(burst_word, burst_pos);
               ans.is_mark  = ~burst_pos[0];
               ans.last     = (burst_pos == irac_pkg::SEQ_LAST);
               ans.status   = irac_pkg::STATUS_OK;
               ans.word     = burst_word;
               ans.position = burst_pos;
               if (burst_pos == irac_pkg::SEQ_LAST) begin
                  burst_active = 1'b0;
                  burst_pos    = '0;
               end else begin
                  burst_pos = burst_pos + 1'b1;
               end
            end
         end
         irac_pkg::KIND_START_STATE: begin
            if (item.mode >= irac_pkg::MODE_COOL && item.mode <= irac_pkg::MODE_FAN) begin
               cmd    = state_word(item.mode, item.fan, item.temp);
               chosen = 1'b1;
            end
         end
         irac_pkg::KIND_START_TOGGLE: begin
            if (item.select < NUM_TOGGLES) begin
               cmd    = TOGGLE_WORDS[item.select[2:0]];
               chosen = 1'b1;
            end
         end
         irac_pkg::KIND_START_EXTRA: begin
            if (item.select < NUM_EXTRAS) begin
               cmd    = EXTRA_WORDS[item.select[1:0]];
               chosen = 1'b1;
            end
         end
         irac_pkg::KIND_START_RAW: begin
            cmd    = item.raw_code;
            chosen = 1'b1;
         end
         default: ;
      endcase
      // Any start, good or bad, ends the burst in progress. A rejected one
      // leaves the held word alone and answers with the off code.
      if (item.kind != irac_pkg::KIND_NEXT) begin
         burst_pos    = '0;
         burst_active = chosen;
         if (chosen) begin
            burst_word = cmd;
            ans.status = irac_pkg::STATUS_OK;
            ans.word   = cmd;
         end else begin
            ans.status = irac_pkg::STATUS_REJECTED;
            ans.word   = irac_pkg::WORD_OFF;
         end
      end
      return ans;
   endfunction

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
         mismatches++;
      end
   endtask

   task automatic check_answer(irac_pkg::rsp_payload_type want,
                               irac_pkg::rsp_payload_type got);
      check_field("duration", want.duration, got.duration);
      check_field("is_mark", want.is_mark, got.is_mark);
      check_field("last", want.last, got.last);
      check_field("status", want.status, got.status);
      check_field("word", want.word, got.word);
      check_field("position", want.position, got.position);
   endtask

   function automatic irac_pkg::req_payload_type make_item(logic [2:0] kind, logic [2:0] mode,
                                                           logic [2:0] fan, logic [7:0] temp,
                                                           logic [3:0] sel,
                                                           logic [irac_pkg::WORD_W-1:0] raw);
      irac_pkg::req_payload_type item;
      item.kind     = kind;
      item.mode     = mode;
      item.fan      = fan;
      item.temp     = temp;
      item.select   = sel;
      item.raw_code = raw;
      return item;
   endfunction

   // An item of the given kind with every other field random.
   function automatic irac_pkg::req_payload_type random_item(logic [2:0] kind);
      return make_item(kind, 3'($urandom_range(7, 0)), 3'($urandom_range(7, 0)),
                       8'($urandom_range(255, 0)), 4'($urandom_range(SELECT_MAX, 0)),
                       24'($urandom_range(24'hFFFFFF, 0)));
   endfunction

   // A start item that the encoder will take, of any of the four kinds.
   function automatic irac_pkg::req_payload_type random_start();
      irac_pkg::req_payload_type item;
      item = random_item(3'($urandom_range(irac_pkg::KIND_START_RAW,
                                           irac_pkg::KIND_START_STATE)));
      case (item.kind)
         irac_pkg::KIND_START_STATE: begin
            item.mode = 3'($urandom_range(irac_pkg::MODE_FAN, irac_pkg::MODE_COOL));
            // Half of the setpoints are drawn from the clamping range widened by two at each end.
            if ($urandom_range(1, 0) != 0) begin
               item.temp = 8'($urandom_range(irac_pkg::TEMP_HIGH + 2, irac_pkg::TEMP_LOW - 2));
            end
         end
         irac_pkg::KIND_START_TOGGLE: item.select = 4'($urandom_range(NUM_TOGGLES - 1, 0));
         irac_pkg::KIND_START_EXTRA:  item.select = 4'($urandom_range(NUM_EXTRAS - 1, 0));
         default: ;
      endcase
      return item;
   endfunction

   // A start item with a selection that the encoder must refuse.
   function automatic irac_pkg::req_payload_type refused_start();
      irac_pkg::req_payload_type item;
      case ($urandom_range(3, 0))
         0: begin
            item = random_item(irac_pkg::KIND_START_STATE);
            item.mode = ($urandom_range(2, 0) == 0) ? irac_pkg::MODE_OFF
                        : 3'($urandom_range(MODE_RESERVED_HI, MODE_RESERVED_LO));
         end
         1: begin
            item = random_item(irac_pkg::KIND_START_TOGGLE);
            item.select = 4'($urandom_range(SELECT_MAX, NUM_TOGGLES));
         end
         2: begin
            item = random_item(irac_pkg::KIND_START_EXTRA);
            item.select = 4'($urandom_range(SELECT_MAX, NUM_EXTRAS));
         end
         default: item = random_item(3'($urandom_range(KIND_RESERVED_HI, KIND_RESERVED_LO)));
      endcase
      return item;
   endfunction

   // Mostly whole bursts: a good start, then all 199 pulls and often one
   // more to see the idle answer, or a burst cut short by the next start.
   // The rest is refused starts, stray pulls and items of any kind.
   task automatic queue_random_traffic(int unsigned count);
      int unsigned queued;
      int unsigned pulls;
      int unsigned pick;
      queued = 0;
      while (queued < count) begin
         pick = $urandom_range(99, 0);
         if (pick < 80) begin
            command_queue.push_back(random_start());
            pick = $urandom_range(99, 0);
            if (pick < 55) begin
               pulls = irac_pkg::SEQ_LAST + 2;
            end else if (pick < 75) begin
               pulls = irac_pkg::SEQ_LAST + 1;
            end else begin
               pulls = $urandom_range(irac_pkg::SEQ_LAST, 1);
            end
            repeat (pulls) command_queue.push_back(random_item(irac_pkg::KIND_NEXT));
            queued += pulls + 1;
         end else begin
            case ($urandom_range(2, 0))
               0:       command_queue.push_back(refused_start());
               1:       command_queue.push_back(random_item(irac_pkg::KIND_NEXT));
               default: command_queue.push_back(random_item(3'($urandom_range(7, 0))));
            endcase
            queued++;
         end
      end
   endtask

   // Hand-picked items: field extremes, every kind, the idle and refused
   // answers, temperature clamping at both ends, forced and out-of-range fan
   // speeds, fan-only mode, and a burst cut short by a new start.
   task automatic queue_directed();
      command_queue.push_back(make_item(irac_pkg::KIND_NEXT, irac_pkg::MODE_OFF, 3'd0, 8'd0,
                                        4'd0, 24'h0));
      command_queue.push_back(make_item(irac_pkg::KIND_START_STATE, irac_pkg::MODE_OFF, 3'd0,
                                        8'd22, 4'd0, 24'h0));
      command_queue.push_back(make_item(irac_pkg::KIND_START_STATE, MODE_RESERVED_LO, 3'd1,
                                        8'd22, 4'd0, 24'h0));
      command_queue.push_back(make_item(irac_pkg::KIND_START_STATE, MODE_RESERVED_HI, 3'd7,
                                        8'd255, SELECT_MAX, 24'hFFFFFF));
      command_queue.push_back(make_item(irac_pkg::KIND_START_STATE, irac_pkg::MODE_COOL, 3'd0,
                                        8'd0, 4'd0, 24'h0));
      command_queue.push_back(make_item(irac_pkg::KIND_NEXT, irac_pkg::MODE_OFF, 3'd0, 8'd0,
                                        4'd0, 24'h0));
      command_queue.push_back(make_item(irac_pkg::KIND_NEXT, MODE_RESERVED_HI, 3'd7, 8'd255,
                                        SELECT_MAX, 24'hFFFFFF));
      command_queue.push_back(make_item(irac_pkg::KIND_START_STATE, irac_pkg::MODE_HEAT, 3'd3,
                                        8'd255, 4'd0, 24'h0));
      command_queue.push_back(make_item(irac_pkg::KIND_START_STATE, irac_pkg::MODE_AUTO, 3'd2,
                                        8'd20, 4'd0, 24'h0));
      command_queue.push_back(make_item(irac_pkg::KIND_START_STATE, irac_pkg::MODE_DRY, 3'd1,
                                        8'd30, 4'd0, 24'h0));
      command_queue.push_back(make_item(irac_pkg::KIND_START_STATE, irac_pkg::MODE_FAN, 3'd7,
                                        8'd17, 4'd0, 24'h0));
      command_queue.push_back(make_item(irac_pkg::KIND_START_STATE, irac_pkg::MODE_COOL, 3'd4,
                                        8'd16, 4'd0, 24'h0));
      command_queue.push_back(make_item(irac_pkg::KIND_START_TOGGLE, irac_pkg::MODE_OFF, 3'd0,
                                        8'd0, 4'd0, 24'h0));
      command_queue.push_back(make_item(irac_pkg::KIND_START_TOGGLE, irac_pkg::MODE_OFF, 3'd0,
                                        8'd0, 4'(NUM_TOGGLES - 1), 24'h0));
      command_queue.push_back(make_item(irac_pkg::KIND_START_TOGGLE, irac_pkg::MODE_OFF, 3'd0,
                                        8'd0, 4'(NUM_TOGGLES), 24'h0));
      command_queue.push_back(make_item(irac_pkg::KIND_START_TOGGLE, irac_pkg::MODE_OFF, 3'd0,
                                        8'd0, SELECT_MAX, 24'h0));
      command_queue.push_back(make_item(irac_pkg::KIND_START_EXTRA, irac_pkg::MODE_OFF, 3'd0,
                                        8'd0, 4'd0, 24'h0));
      command_queue.push_back(make_item(irac_pkg::KIND_START_EXTRA, irac_pkg::MODE_OFF, 3'd0,
                                        8'd0, 4'(NUM_EXTRAS - 1), 24'h0));
      command_queue.push_back(make_item(irac_pkg::KIND_START_EXTRA, irac_pkg::MODE_OFF, 3'd0,
                                        8'd0, 4'(NUM_EXTRAS), 24'h0));
      command_queue.push_back(make_item(irac_pkg::KIND_START_EXTRA, irac_pkg::MODE_OFF, 3'd0,
                                        8'd0, SELECT_MAX, 24'h0));
      command_queue.push_back(make_item(irac_pkg::KIND_START_RAW, irac_pkg::MODE_OFF, 3'd0,
                                        8'd0, 4'd0, 24'h0));
      command_queue.push_back(make_item(irac_pkg::KIND_START_RAW, irac_pkg::MODE_OFF, 3'd0,
                                        8'd0, 4'd0, 24'hFFFFFF));
      command_queue.push_back(make_item(irac_pkg::KIND_NEXT, irac_pkg::MODE_OFF, 3'd0, 8'd0,
                                        4'd0, 24'h0));
      command_queue.push_back(make_item(KIND_RESERVED_LO, irac_pkg::MODE_COOL, 3'd0, 8'd22,
                                        4'd0, 24'h0));
      command_queue.push_back(make_item(KIND_RESERVED_HI, irac_pkg::MODE_COOL, 3'd0, 8'd22,
                                        4'd0, 24'h0));
   endtask

   // Writes all seven timing registers, then the unused index, which the
   // encoder must ignore. Only called while nothing is in flight.
   task automatic program_timings(irac_pkg::regs_type values);
      for (int i = 0; i < irac_pkg::NUM_REGS; i++) begin
         @(posedge clock);
         csr_write_enable <= 1'b1;
         csr_index        <= 3'(i);
         csr_write_data   <= values[i];
      end
      @(posedge clock);
      csr_index      <= REG_SPARE;
      csr_write_data <= 16'($urandom_range(16'hFFFF, 0));
      timing_regs = values;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Waits until every command has been taken and answered, then lets the
   // pipeline settle.
   task automatic wait_quiet();
      while (command_queue.size() != 0 || req_ch.valid || owed_answers.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Command driver. An item is taken at an edge where valid and ready are
   // both high; the answer is predicted there. Once the current item has
   // gone (or none is offered) the next one is put up, unless this cycle
   // is picked to idle.
   always @(posedge clock) begin : command_driver
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            owed_answers.push_back(encode_item(req_ch.payload));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (command_queue.size() != 0
                && (no_stall_phase || $urandom_range(99, 0) >= IDLE_PCT)) begin
               req_ch.payload <= command_queue.pop_front();
               req_ch.valid   <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Answer monitor: compares each answer taken with the oldest one owed,
   // field by field, and holds ready low at random.
   always @(posedge clock) begin : answer_monitor
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (owed_answers.size() == 0) begin
               $display("%0t: answer with nothing owed, got 0x%0h", $time, rsp_ch.payload);
               mismatches++;
            end else begin
               check_answer(owed_answers.pop_front(), rsp_ch.payload);
            end
         end
         rsp_ch.ready <= no_stall_phase || ($urandom_range(99, 0) >= IDLE_PCT);
      end
   end

   // Watchdog: gives up if nothing moves on either side for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("ir_ac_frame_encoder_core: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Test sequence: hand-picked items under the reset timings, then four
   // random phases under random, all-ones and all-zeros timings. The
   // all-ones phase runs with no idling on either side.
   initial begin : test_sequence
      irac_pkg::regs_type setting;
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      no_stall_phase   = 1'b0;
      timing_regs      = irac_pkg::REG_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      queue_directed();
      wait_quiet();

      for (int i = 0; i < irac_pkg::NUM_REGS; i++) begin
         setting[i] = 16'($urandom_range(16'hFFFF, 0));
      end
      program_timings(setting);
      queue_random_traffic(PHASE_ITEMS);
      wait_quiet();

      setting = '1;
      program_timings(setting);
      no_stall_phase = 1'b1;
      queue_random_traffic(PHASE_ITEMS);
      wait_quiet();
      no_stall_phase = 1'b0;

      setting = '0;
      program_timings(setting);
      queue_random_traffic(PHASE_ITEMS);
      wait_quiet();

      for (int i = 0; i < irac_pkg::NUM_REGS; i++) begin
         setting[i] = 16'($urandom_range(16'hFFFF, 0));
      end
      program_timings(setting);
      queue_random_traffic(PHASE_ITEMS);
      wait_quiet();

      if (mismatches == 0) begin
         $display("ir_ac_frame_encoder_core: match");
      end else begin
         $display("ir_ac_frame_encoder_core: mismatch");
      end
      $finish;
   end

endmodule
